// File: rtl/tpot_pkg.sv
// ----------------------------------------------------------------------------
// tpot_pkg: shared types and constants for the tick prescaler
// Command codes, prescaler reload values and the structs that pass between
// the prescaler, the timer bank and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tpot_pkg;

  localparam int TIMERS_DEFAULT = 2;
  localparam int TIMERS_MAX     = 16;

  localparam int ID_W    = 4;
  localparam int LENGTH_W = 16;

  localparam logic [3:0] MS_RELOAD     = 4'd10;
  localparam logic [3:0] TENTH_RELOAD  = 4'd10;
  localparam logic [2:0] HALF_RELOAD   = 3'd5;
  localparam logic [1:0] SECOND_RELOAD = 2'd2;
  localparam logic [1:0] SECOND_START  = 2'd1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic set;
    logic query;
  } op_t;

  typedef struct packed {
    logic p10ms;
    logic p100ms;
    logic p500ms;
    logic p1s;
  } pulses_t;

endpackage

`default_nettype wire

// File: rtl/tpot_prescaler.sv
// ----------------------------------------------------------------------------
// tpot_prescaler: cascaded millisecond tick divider
// Four down-counters in a chain divide the 1 ms tick into 10 ms, 100 ms,
// 500 ms and 1 s pulses; a stage reloads in place of stepping down to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tpot_prescaler
  import tpot_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    tick,
  output pulses_t      pulses
);

  logic [3:0] ms_stage, ms_stage_next, ms_dec;
  logic [3:0] tenth_stage, tenth_stage_next, tenth_dec;
  logic [2:0] half_stage, half_stage_next, half_dec;
  logic [1:0] second_stage, second_stage_next, second_dec;

  always_comb begin
    ms_dec     = ms_stage - 4'd1;
    tenth_dec  = tenth_stage - 4'd1;
    half_dec   = half_stage - 3'd1;
    second_dec = second_stage - 2'd1;

    pulses.p10ms  = tick && (ms_dec == 4'd0);
    pulses.p100ms = pulses.p10ms && (tenth_dec == 4'd0);
    pulses.p500ms = pulses.p100ms && (half_dec == 3'd0);
    pulses.p1s    = pulses.p500ms && (second_dec == 2'd0);

    ms_stage_next     = ms_stage;
    tenth_stage_next  = tenth_stage;
    half_stage_next   = half_stage;
    second_stage_next = second_stage;
    if (tick) begin
      ms_stage_next = pulses.p10ms ? MS_RELOAD : ms_dec;
    end
    if (pulses.p10ms) begin
      tenth_stage_next = pulses.p100ms ? TENTH_RELOAD : tenth_dec;
    end
    if (pulses.p100ms) begin
      half_stage_next = pulses.p500ms ? HALF_RELOAD : half_dec;
    end
    if (pulses.p500ms) begin
      second_stage_next = pulses.p1s ? SECOND_RELOAD : second_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_stage     <= MS_RELOAD;
      tenth_stage  <= TENTH_RELOAD;
      half_stage   <= HALF_RELOAD;
      second_stage <= SECOND_START;
    end else begin
      ms_stage     <= ms_stage_next;
      tenth_stage  <= tenth_stage_next;
      half_stage   <= half_stage_next;
      second_stage <= second_stage_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tpot_timers.sv
// ----------------------------------------------------------------------------
// tpot_timers: bank of one-shot software timers
// Each timer holds a count in 10 ms units and a running flag. Counts age on
// every 10 ms pulse; a set loads a timer and a query reports expiry once.
// ----------------------------------------------------------------------------
`default_nettype none

module tpot_timers
  import tpot_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire op_t                 op,
  input  wire logic                age,
  input  wire logic [ID_W-1:0]     timer_id,
  input  wire logic [LENGTH_W-1:0] length,
  output logic                     accepted,
  output logic                     expired
);

  logic [LENGTH_W-1:0] timer_count [TIMERS];
  logic [TIMERS-1:0]   timer_running;
  logic [TIMERS-1:0]   hit;
  logic [TIMERS-1:0]   done;
  logic                id_ok;

  always_comb begin
    id_ok = {1'b0, timer_id} < (ID_W + 1)'(TIMERS);
    for (int k = 0; k < TIMERS; k++) begin
      hit[k]  = id_ok && (timer_id == ID_W'(k));
      done[k] = timer_running[k] && (timer_count[k] == '0);
    end
    accepted = op.set && id_ok;
    expired  = op.query && |(hit & done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TIMERS; k++) begin
        timer_count[k]   <= '0;
        timer_running[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < TIMERS; k++) begin
        if (op.tick && age && (timer_count[k] != '0)) begin
          timer_count[k] <= timer_count[k] - LENGTH_W'(1);
        end
        if (op.set && hit[k]) begin
          timer_count[k]   <= length;
          timer_running[k] <= (length != '0);
        end
        if (op.query && hit[k] && done[k]) begin
          timer_running[k] <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tick_prescaler_with_oneshot_timers.sv
// ----------------------------------------------------------------------------
// tick_prescaler_with_oneshot_timers: tick prescaler with one-shot timers
// Top level: input register, command decode, prescaler and timer bank, and
// the result register with its handshake.
// ----------------------------------------------------------------------------
// Each input word carries a command (1 ms tick, timer set or timer query),
// a timer id and a length. Words enter on in_valid/in_stall and every word
// gives exactly one result word on out_valid/out_stall.
// A word is registered on entry, worked on from the input register against the
// prescaler and timer state, and written to the result register. One word
// is taken per cycle while the receiver keeps up.
// A tick yields the 10 ms, 100 ms, 500 ms and 1 s pulses; a set yields
// accepted; a query yields expired. Other fields of a result are zero.
// Reset empties both registers, reloads the prescaler chain (the first 1 s
// pulse comes 0.5 s after reset) and stops and clears every timer.
// When the receiver stalls, the result is held and the input register takes
// a word only while it is empty; once it holds one, in_stall is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_prescaler_with_oneshot_timers
  import tpot_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          command,
  input  wire logic [ID_W-1:0]     timer_id,
  input  wire logic [LENGTH_W-1:0] length,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     pulse_10ms,
  output logic                     pulse_100ms,
  output logic                     pulse_500ms,
  output logic                     pulse_1s,
  output logic                     accepted,
  output logic                     expired
);

  logic                s1_valid;
  logic [1:0]          s1_command;
  logic [ID_W-1:0]     s1_timer_id;
  logic [LENGTH_W-1:0] s1_length;
  logic                advance;
  logic                fire;
  op_t                 op;
  pulses_t             pulses;
  logic                set_ok;
  logic                query_hit;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign fire     = s1_valid && advance;

  always_comb begin
    op = '0;
    unique case (cmd_t'(s1_command))
      CMD_TICK:  op.tick  = fire;
      CMD_SET:   op.set   = fire;
      CMD_QUERY: op.query = fire;
      default:   op = '0;
    endcase
  end

  tpot_prescaler u_prescaler (
    .clk    (clk),
    .rst    (rst),
    .tick   (op.tick),
    .pulses (pulses)
  );

  tpot_timers #(
    .TIMERS (TIMERS)
  ) u_timers (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .age      (pulses.p10ms),
    .timer_id (s1_timer_id),
    .length   (s1_length),
    .accepted (set_ok),
    .expired  (query_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_command  <= command;
      s1_timer_id <= timer_id;
      s1_length   <= length;
    end
    if (fire) begin
      pulse_10ms  <= pulses.p10ms;
      pulse_100ms <= pulses.p100ms;
      pulse_500ms <= pulses.p500ms;
      pulse_1s    <= pulses.p1s;
      accepted    <= set_ok;
      expired     <= query_hit;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tpot_checker.sv
// ----------------------------------------------------------------------------
// tpot_checker: port-level checks for the tick prescaler
// Watches the result channel for consistent pulse nesting, exclusive result
// kinds, a clean reset and held words under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tpot_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic pulse_10ms,
  input wire logic pulse_100ms,
  input wire logic pulse_500ms,
  input wire logic pulse_1s,
  input wire logic accepted,
  input wire logic expired
);

  // A slower pulse only ever fires together with every faster one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!pulse_100ms || pulse_10ms) && (!pulse_500ms || pulse_100ms)
                   && (!pulse_1s || pulse_500ms)))
    else $error("pulse cascade broken");

  // A word reports a tick, a set or a query, never a mixture.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (accepted || expired)) |->
      (!(accepted && expired) && !pulse_10ms && !pulse_100ms
       && !pulse_500ms && !pulse_1s))
    else $error("result mixes command kinds");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(pulse_10ms) && $stable(pulse_1s)
       && $stable(accepted) && $stable(expired)))
    else $error("stalled result word changed");

endmodule

bind tick_prescaler_with_oneshot_timers tpot_checker u_checker (.*);

`default_nettype wire
